// ===== rtl/core/lla_pkg.sv =====
// Shared types and constants for the life-like automaton step engine.
package lla_pkg;

   // Default store size in interior cells.
   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;

   // Port field widths.
   localparam int OP_W    = 2;
   localparam int COORD_W = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;
   localparam int SIZE_W  = 7;
   localparam int MODE_W  = 3;
   localparam int MASK_W  = 9;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WRAP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SURVIVE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BIRTH   = 3'd4;

   // Register reset values.
   localparam logic [SIZE_W-1:0] WIDTH_RST   = 7'd64;
   localparam logic [SIZE_W-1:0] HEIGHT_RST  = 7'd64;
   localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;
   localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;

   // Topology codes.
   localparam logic [MODE_W-1:0] WRAP_PLANE      = 3'd0;
   localparam logic [MODE_W-1:0] WRAP_RING       = 3'd1;
   localparam logic [MODE_W-1:0] WRAP_MOBIUS     = 3'd2;
   localparam logic [MODE_W-1:0] WRAP_TORUS      = 3'd3;
   localparam logic [MODE_W-1:0] WRAP_SPHERE     = 3'd4;
   localparam logic [MODE_W-1:0] WRAP_KLEIN      = 3'd5;
   localparam logic [MODE_W-1:0] WRAP_PROJECTIVE = 3'd6;

   // Sphere edge codes: {left, right, top, bottom}.
   localparam logic [3:0] SPH_TOP_LEFT     = 4'hA;
   localparam logic [3:0] SPH_BOTTOM_RIGHT = 4'h5;
   localparam logic [3:0] SPH_BOTTOM_LEFT  = 4'h9;
   localparam logic [3:0] SPH_LEFT         = 4'h8;
   localparam logic [3:0] SPH_TOP_RIGHT    = 4'h6;
   localparam logic [3:0] SPH_RIGHT        = 4'h4;
   localparam logic [3:0] SPH_TOP          = 4'h2;
   localparam logic [3:0] SPH_BOTTOM       = 4'h1;

   // Per-cell sequencer phases: 0..7 neighbors, then center, then write.
   localparam logic [3:0] PH_CENTER = 4'd8;
   localparam logic [3:0] PH_WRITE  = 4'd9;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_STEP
   } state_type;

endpackage

// ===== rtl/core/life_like_automaton_step.sv =====
// Top level of the life-like automaton step engine with its sequencer.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_op, req_column, req_row, req_cell_in
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_cell_out
//  csr     | in        | csr_write_en         | csr_index, csr_write_data
//
// After reset a clearing pass zeroes every address of both planes.
// A write goes into both planes on acceptance; a read beat is offered after ST_READ.
// A step visits each of the W*H cells: the shared plane read port serves the eight
// neighbors and the center of one cell, one address per cycle.
// No new request beat is taken while a response beat waits under rsp_stall.
module life_like_automaton_step #(
   parameter int MAX_COLS = lla_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = lla_pkg::MAX_ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lla_pkg::OP_W-1:0]       req_op,
   input  logic [lla_pkg::COORD_W-1:0]    req_column,
   input  logic [lla_pkg::COORD_W-1:0]    req_row,
   input  logic                           req_cell_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_cell_out,
   input  logic                           csr_write_en,
   input  logic [lla_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lla_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int STRIDE = MAX_COLS + 2;
   localparam int DEPTH  = (MAX_COLS + 2) * (MAX_ROWS + 2);
   localparam int AW     = $clog2(DEPTH);
   localparam int CMAX   = (MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS) + 2;
   localparam int CWB    = $clog2(CMAX);
   localparam int CW     = CWB > lla_pkg::COORD_W ? CWB : lla_pkg::COORD_W;

   localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLS + 1);
   localparam logic [CW-1:0] ROW_LAST = CW'(MAX_ROWS + 1);
   localparam logic [CW-1:0] ONE      = CW'(1);

   // Configuration registers.
   logic [lla_pkg::SIZE_W-1:0] width_ff, height_ff;
   logic [lla_pkg::MODE_W-1:0] mode_ff;
   logic [lla_pkg::MASK_W-1:0] survive_ff, birth_ff;

   // Control and datapath registers.
   lla_pkg::state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          sel_ff, sel_in;
   logic [CW-1:0] cc_ff, cc_in, cr_ff, cr_in;
   logic [3:0]    ph_ff, ph_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          dead_ff, dead_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_cell_ff, rsp_cell_in;

   // Effective sizes and neighbor mapping signals.
   logic [CW-1:0] w_eff, h_eff;
   logic [CW-1:0] nb_c, nb_r, lc, lr;
   logic          le, re, te, be, oc, orr, map_dead;
   logic [CW-1:0] port_c, port_r;
   logic          port_in_store, req_accept;

   // Memory ports.
   logic          wr_a, wr_b, wr_data;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          rd_a, rd_b, rd_bit;

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [CW-1:0] r);
      return AW'(32'(r) * 32'(STRIDE) + 32'(c));
   endfunction

   function automatic logic [CW-1:0] wrap_idx(input logic [CW-1:0] v, input logic [CW-1:0] n);
      logic [CW-1:0] res;
      res = v;
      if (v == '0) begin
         res = n;
      end else if (v > n) begin
         res = ONE;
      end
      return res;
   endfunction

   function automatic logic [CW-1:0] eff_size(input logic [lla_pkg::SIZE_W-1:0] v,
                                              input logic [CW-1:0] maxv);
      logic [CW-1:0] res;
      res = CW'(v);
      if (v == '0) begin
         res = ONE;
      end else if (CW'(v) > maxv) begin
         res = maxv;
      end
      return res;
   endfunction

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= lla_pkg::WIDTH_RST;
         height_ff  <= lla_pkg::HEIGHT_RST;
         mode_ff    <= lla_pkg::WRAP_PLANE;
         survive_ff <= lla_pkg::SURVIVE_RST;
         birth_ff   <= lla_pkg::BIRTH_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            lla_pkg::REG_WIDTH:   width_ff   <= csr_write_data[lla_pkg::SIZE_W-1:0];
            lla_pkg::REG_HEIGHT:  height_ff  <= csr_write_data[lla_pkg::SIZE_W-1:0];
            lla_pkg::REG_WRAP:    mode_ff    <= csr_write_data[lla_pkg::MODE_W-1:0];
            lla_pkg::REG_SURVIVE: survive_ff <= csr_write_data;
            lla_pkg::REG_BIRTH:   birth_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign w_eff = eff_size(width_ff, CW'(MAX_COLS));
   assign h_eff = eff_size(height_ff, CW'(MAX_ROWS));

   // Neighbor coordinates of the current phase around the cell being built.
   always_comb begin
      nb_c = cc_ff;
      nb_r = cr_ff;
      case (ph_ff)
         4'd0: begin nb_c = cc_ff - ONE; nb_r = cr_ff - ONE; end
         4'd1: begin nb_r = cr_ff - ONE; end
         4'd2: begin nb_c = cc_ff + ONE; nb_r = cr_ff - ONE; end
         4'd3: begin nb_c = cc_ff - ONE; end
         4'd4: begin nb_c = cc_ff + ONE; end
         4'd5: begin nb_c = cc_ff - ONE; nb_r = cr_ff + ONE; end
         4'd6: begin nb_r = cr_ff + ONE; end
         4'd7: begin nb_c = cc_ff + ONE; nb_r = cr_ff + ONE; end
         default: ;
      endcase
   end

   // Topology remap of a neighbor that falls on the border.
   assign le  = (nb_c == '0);
   assign re  = (nb_c > w_eff);
   assign te  = (nb_r == '0);
   assign be  = (nb_r > h_eff);
   assign oc  = le || re;
   assign orr = te || be;

   always_comb begin
      lc       = nb_c;
      lr       = nb_r;
      map_dead = 1'b0;
      if (oc || orr) begin
         case (mode_ff)
            lla_pkg::WRAP_RING: begin
               if (oc) lc = wrap_idx(nb_c, w_eff);
            end
            lla_pkg::WRAP_MOBIUS: begin
               if (oc) begin
                  lc = wrap_idx(nb_c, w_eff);
                  lr = h_eff + ONE - nb_r;
               end
            end
            lla_pkg::WRAP_TORUS: begin
               if (oc) lc = wrap_idx(nb_c, w_eff);
               if (orr) lr = wrap_idx(nb_r, h_eff);
            end
            lla_pkg::WRAP_SPHERE: begin
               case ({le, re, te, be})
                  lla_pkg::SPH_TOP_LEFT, lla_pkg::SPH_BOTTOM_RIGHT: map_dead = 1'b1;
                  lla_pkg::SPH_BOTTOM_LEFT: begin lc = w_eff; lr = ONE;   end
                  lla_pkg::SPH_LEFT:        begin lc = nb_r;  lr = ONE;   end
                  lla_pkg::SPH_TOP_RIGHT:   begin lc = ONE;   lr = h_eff; end
                  lla_pkg::SPH_RIGHT:       begin lc = nb_r;  lr = h_eff; end
                  lla_pkg::SPH_TOP:         begin lc = ONE;   lr = nb_c;  end
                  lla_pkg::SPH_BOTTOM:      begin lc = w_eff; lr = nb_c;  end
                  default: ;
               endcase
            end
            lla_pkg::WRAP_KLEIN: begin
               if (oc) lc = wrap_idx(nb_c, w_eff);
               if (orr) lr = wrap_idx(nb_r, h_eff);
               if (oc) lr = h_eff + ONE - lr;
            end
            lla_pkg::WRAP_PROJECTIVE: begin
               if (oc) lc = wrap_idx(nb_c, w_eff);
               if (orr) lc = w_eff + ONE - lc;
               if (orr) lr = wrap_idx(nb_r, h_eff);
               if (oc) lr = h_eff + ONE - lr;
            end
            default: ;
         endcase
      end
      // A mapped cell outside the store reads dead.
      if (lc > COL_LAST || lr > ROW_LAST) begin
         map_dead = 1'b1;
      end
   end

   // Request address decode.
   assign port_c        = CW'(req_column);
   assign port_r        = CW'(req_row);
   assign port_in_store = (port_c <= COL_LAST) && (port_r <= ROW_LAST);
   assign req_stall     = (state_ff != lla_pkg::ST_IDLE) || rsp_valid_ff;
   assign req_accept    = req_valid && !req_stall;

   // Read data of the current plane, forced dead when the address was off the store.
   assign rd_bit = (sel_ff ? rd_b : rd_a) & ~dead_ff;

   // Sequencer: next state, memory controls and datapath updates.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sel_in       = sel_ff;
      cc_in        = cc_ff;
      cr_in        = cr_ff;
      ph_in        = ph_ff;
      cnt_in       = cnt_ff;
      dead_in      = map_dead;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cell_in  = rsp_cell_ff;
      wr_a         = 1'b0;
      wr_b         = 1'b0;
      wr_data      = 1'b0;
      wr_addr      = addr_of(cc_ff, cr_ff);
      rd_addr      = addr_of(lc, lr);
      case (state_ff)
         lla_pkg::ST_CLEAR: begin
            wr_a    = 1'b1;
            wr_b    = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = lla_pkg::ST_IDLE;
            end
         end
         lla_pkg::ST_IDLE: begin
            rd_addr = addr_of(port_c, port_r);
            dead_in = !port_in_store;
            if (req_accept) begin
               case (req_op)
                  lla_pkg::OP_WRITE: begin
                     wr_a    = port_in_store;
                     wr_b    = port_in_store;
                     wr_data = req_cell_in;
                     wr_addr = addr_of(port_c, port_r);
                  end
                  lla_pkg::OP_READ: state_in = lla_pkg::ST_READ;
                  lla_pkg::OP_STEP: begin
                     state_in = lla_pkg::ST_STEP;
                     cc_in    = ONE;
                     cr_in    = ONE;
                     ph_in    = '0;
                     cnt_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         lla_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_cell_in  = rd_bit;
            state_in     = lla_pkg::ST_IDLE;
         end
         lla_pkg::ST_STEP: begin
            if (ph_ff != lla_pkg::PH_WRITE) begin
               ph_in = ph_ff + 4'd1;
            end
            // Neighbor data arrives one phase after its address.
            if (ph_ff != '0 && ph_ff <= lla_pkg::PH_CENTER) begin
               cnt_in = cnt_ff + {3'b000, rd_bit};
            end
            if (ph_ff == lla_pkg::PH_WRITE) begin
               wr_data = rd_bit ? survive_ff[cnt_ff] : birth_ff[cnt_ff];
               wr_a    = sel_ff;
               wr_b    = !sel_ff;
               ph_in   = '0;
               cnt_in  = '0;
               if (cc_ff == w_eff) begin
                  cc_in = ONE;
                  cr_in = cr_ff + ONE;
                  if (cr_ff == h_eff) begin
                     sel_in   = !sel_ff;
                     state_in = lla_pkg::ST_IDLE;
                  end
               end else begin
                  cc_in = cc_ff + ONE;
               end
            end
         end
         default: state_in = lla_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lla_pkg::ST_CLEAR;
         clr_ff       <= '0;
         sel_ff       <= 1'b0;
         ph_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sel_ff       <= sel_in;
         ph_ff        <= ph_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cc_ff       <= cc_in;
      cr_ff       <= cr_in;
      dead_ff     <= dead_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_out = rsp_cell_ff;

   // The two cell planes.
   lla_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_plane_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_a)
   );

   lla_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_plane_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_b)
   );

`ifndef SYNTH
   // A response beat only follows a read.
   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == lla_pkg::ST_READ))
      else $error("response without read");

   // The phase counter stays within the per-cell schedule.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lla_pkg::ST_STEP) |-> (ph_ff <= lla_pkg::PH_WRITE))
      else $error("phase out of range");

   // The cell being built lies in the interior.
   a_cell_interior: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lla_pkg::ST_STEP) |->
         (cc_ff >= ONE && cc_ff <= w_eff && cr_ff >= ONE && cr_ff <= h_eff))
      else $error("cell outside interior");

   // The plane select flips exactly when a step finishes.
   a_sel_flip: assert property (@(posedge clock) disable iff (reset)
      (sel_ff != $past(sel_ff)) |-> $past(state_ff == lla_pkg::ST_STEP))
      else $error("plane select changed outside a step");
`endif

endmodule

// ===== rtl/core/lla_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module lla_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4356
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the life-like automaton step engine.
`timescale 1ns / 1ps

module tb;

   localparam int STRIDE = lla_pkg::MAX_COLS_DEF + 2;
   localparam int DEPTH  = STRIDE * (lla_pkg::MAX_ROWS_DEF + 2);
   localparam int CRD_W  = lla_pkg::COORD_W;

   // Operation and topology codes outside the defined set.
   localparam logic [lla_pkg::OP_W-1:0]   OP_UNKNOWN   = 2'd3;
   localparam logic [lla_pkg::MODE_W-1:0] WRAP_UNKNOWN = 3'd7;

   // One row of the directed stimulus table; has_ref marks a typed-in read value.
   typedef struct packed {
      logic [lla_pkg::OP_W-1:0]    op;
      logic [lla_pkg::COORD_W-1:0] col;
      logic [lla_pkg::COORD_W-1:0] row;
      logic                        cin;
      logic                        has_ref;
      logic                        ref_val;
   } cmd_type;

   localparam int N_DIR = 22;
   localparam cmd_type DIRECTED [N_DIR] = '{
      '{lla_pkg::OP_READ,  7'd1,   7'd1,   1'b0, 1'b1, 1'b0},
      '{lla_pkg::OP_WRITE, 7'd1,   7'd1,   1'b1, 1'b0, 1'b0},
      '{lla_pkg::OP_READ,  7'd1,   7'd1,   1'b0, 1'b1, 1'b1},
      '{lla_pkg::OP_READ,  7'd0,   7'd0,   1'b0, 1'b1, 1'b0},
      '{lla_pkg::OP_WRITE, 7'd127, 7'd127, 1'b1, 1'b0, 1'b0},
      '{lla_pkg::OP_READ,  7'd127, 7'd127, 1'b0, 1'b1, 1'b0},
      '{lla_pkg::OP_WRITE, 7'd66,  7'd3,   1'b1, 1'b0, 1'b0},
      '{lla_pkg::OP_READ,  7'd66,  7'd3,   1'b0, 1'b1, 1'b0},
      '{lla_pkg::OP_WRITE, 7'd65,  7'd65,  1'b1, 1'b0, 1'b0},
      '{lla_pkg::OP_READ,  7'd65,  7'd65,  1'b0, 1'b1, 1'b1},
      '{lla_pkg::OP_WRITE, 7'd64,  7'd64,  1'b1, 1'b0, 1'b0},
      '{lla_pkg::OP_READ,  7'd64,  7'd64,  1'b0, 1'b1, 1'b1},
      '{lla_pkg::OP_WRITE, 7'd10,  7'd9,   1'b1, 1'b0, 1'b0},
      '{lla_pkg::OP_WRITE, 7'd10,  7'd10,  1'b1, 1'b0, 1'b0},
      '{lla_pkg::OP_WRITE, 7'd10,  7'd11,  1'b1, 1'b0, 1'b0},
      '{OP_UNKNOWN,        7'd10,  7'd10,  1'b0, 1'b0, 1'b0},
      '{lla_pkg::OP_STEP,  7'd0,   7'd0,   1'b0, 1'b0, 1'b0},
      '{lla_pkg::OP_READ,  7'd9,   7'd10,  1'b0, 1'b0, 1'b0},
      '{lla_pkg::OP_READ,  7'd10,  7'd9,   1'b0, 1'b0, 1'b0},
      '{lla_pkg::OP_READ,  7'd10,  7'd10,  1'b0, 1'b0, 1'b0},
      '{lla_pkg::OP_READ,  7'd1,   7'd1,   1'b0, 1'b0, 1'b0},
      '{lla_pkg::OP_READ,  7'd65,  7'd65,  1'b0, 1'b0, 1'b0}
   };

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [lla_pkg::OP_W-1:0]       req_op;
   logic [lla_pkg::COORD_W-1:0]    req_column;
   logic [lla_pkg::COORD_W-1:0]    req_row;
   logic                           req_cell_in;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic                           rsp_cell_out;
   logic                           csr_write_en;
   logic [lla_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [lla_pkg::CSR_DATA_W-1:0] csr_write_data;

   // Predicted grid state and register copies.
   bit       plane_a [DEPTH];
   bit       plane_b [DEPTH];
   bit       cur_sel;
   int       cfg_w, cfg_h;
   bit [2:0] cfg_wrap;
   bit [8:0] cfg_survive, cfg_birth;

   bit cell_q [$];
   int errors;
   bit quiet;
   bit long_hold;

   life_like_automaton_step u_top (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic bit get_cell(int c, int r);
      if (c > lla_pkg::MAX_COLS_DEF + 1 || r > lla_pkg::MAX_ROWS_DEF + 1) return 1'b0;
      return cur_sel ? plane_b[r * STRIDE + c] : plane_a[r * STRIDE + c];
   endfunction

   function automatic int wrap_coord(int v, int n);
      if (v == 0) return n;
      if (v > n) return 1;
      return v;
   endfunction

   // Value of a neighbor after the topology maps border positions.
   function automatic bit neighbor_cell(int c, int r, int w, int h);
      bit le, re, te, be, oc, orr;
      int lc, lr;
      logic [3:0] sph;
      le = (c == 0); re = (c > w); te = (r == 0); be = (r > h);
      oc = le | re; orr = te | be;
      lc = c; lr = r;
      if (!oc && !orr) return get_cell(c, r);
      case (cfg_wrap)
         lla_pkg::WRAP_RING: begin
            if (oc) lc = wrap_coord(c, w);
         end
         lla_pkg::WRAP_MOBIUS: begin
            if (oc) begin
               lc = wrap_coord(c, w);
               lr = h + 1 - r;
            end
         end
         lla_pkg::WRAP_TORUS: begin
            if (oc) lc = wrap_coord(c, w);
            if (orr) lr = wrap_coord(r, h);
         end
         lla_pkg::WRAP_SPHERE: begin
            sph = {le, re, te, be};
            case (sph)
               lla_pkg::SPH_TOP_LEFT, lla_pkg::SPH_BOTTOM_RIGHT: return 1'b0;
               lla_pkg::SPH_BOTTOM_LEFT: begin lc = w; lr = 1; end
               lla_pkg::SPH_LEFT:        begin lc = r; lr = 1; end
               lla_pkg::SPH_TOP_RIGHT:   begin lc = 1; lr = h; end
               lla_pkg::SPH_RIGHT:       begin lc = r; lr = h; end
               lla_pkg::SPH_TOP:         begin lc = 1; lr = c; end
               lla_pkg::SPH_BOTTOM:      begin lc = w; lr = c; end
               default: ;
            endcase
         end
         lla_pkg::WRAP_KLEIN: begin
            if (oc) lc = wrap_coord(c, w);
            if (orr) lr = wrap_coord(r, h);
            if (oc) lr = h + 1 - lr;
         end
         lla_pkg::WRAP_PROJECTIVE: begin
            if (oc) lc = wrap_coord(c, w);
            if (orr) lc = w + 1 - lc;
            if (orr) lr = wrap_coord(r, h);
            if (oc) lr = h + 1 - lr;
         end
         default: ;
      endcase
      return get_cell(lc, lr);
   endfunction

   // Compute the next generation into the other plane, then swap.
   task automatic advance_generation();
      int w, h, n, idx;
      bit nxt;
      w = (cfg_w == 0) ? 1 : (cfg_w > lla_pkg::MAX_COLS_DEF ? lla_pkg::MAX_COLS_DEF : cfg_w);
      h = (cfg_h == 0) ? 1 : (cfg_h > lla_pkg::MAX_ROWS_DEF ? lla_pkg::MAX_ROWS_DEF : cfg_h);
      for (int c = 1; c <= w; c++) begin
         for (int r = 1; r <= h; r++) begin
            n = neighbor_cell(c - 1, r - 1, w, h) + neighbor_cell(c, r - 1, w, h)
              + neighbor_cell(c + 1, r - 1, w, h) + neighbor_cell(c - 1, r, w, h)
              + neighbor_cell(c + 1, r, w, h) + neighbor_cell(c - 1, r + 1, w, h)
              + neighbor_cell(c, r + 1, w, h) + neighbor_cell(c + 1, r + 1, w, h);
            nxt = get_cell(c, r) ? cfg_survive[n] : cfg_birth[n];
            idx = r * STRIDE + c;
            if (cur_sel) plane_a[idx] = nxt;
            else plane_b[idx] = nxt;
         end
      end
      cur_sel = ~cur_sel;
   endtask

   // Update the prediction for one accepted request beat.
   task automatic apply_request(cmd_type cmd);
      int c, r;
      c = cmd.col; r = cmd.row;
      case (cmd.op)
         lla_pkg::OP_WRITE: begin
            if (c <= lla_pkg::MAX_COLS_DEF + 1 && r <= lla_pkg::MAX_ROWS_DEF + 1) begin
               plane_a[r * STRIDE + c] = cmd.cin;
               plane_b[r * STRIDE + c] = cmd.cin;
            end
         end
         lla_pkg::OP_READ: cell_q.push_back(cmd.has_ref ? cmd.ref_val : get_cell(c, r));
         lla_pkg::OP_STEP: advance_generation();
         default: ;
      endcase
   endtask

   // Offer one request beat, with an occasional idle burst ahead of it.
   task automatic send_request(cmd_type cmd);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= cmd.op;
      req_column  <= cmd.col;
      req_row     <= cmd.row;
      req_cell_in <= cmd.cin;
      do @(posedge clock); while (req_stall);
      apply_request(cmd);
   endtask

   // Wait for all reads, then prove the block idle with one more read.
   task automatic wait_idle();
      cmd_type probe;
      probe = '{lla_pkg::OP_READ, 7'd1, 7'd1, 1'b0, 1'b0, 1'b0};
      req_valid <= 1'b0;
      @(posedge clock);
      while (cell_q.size() != 0) @(posedge clock);
      send_request(probe);
      req_valid <= 1'b0;
      @(posedge clock);
      while (cell_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_regs(int w, int h, bit [2:0] wrap, bit [8:0] surv, bit [8:0] brth);
      csr_write_en <= 1'b1;
      csr_index <= lla_pkg::REG_WIDTH;   csr_write_data <= 9'(w);    @(posedge clock);
      csr_index <= lla_pkg::REG_HEIGHT;  csr_write_data <= 9'(h);    @(posedge clock);
      csr_index <= lla_pkg::REG_WRAP;    csr_write_data <= 9'(wrap); @(posedge clock);
      csr_index <= lla_pkg::REG_SURVIVE; csr_write_data <= surv;     @(posedge clock);
      csr_index <= lla_pkg::REG_BIRTH;   csr_write_data <= brth;     @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_w = w; cfg_h = h; cfg_wrap = wrap; cfg_survive = surv; cfg_birth = brth;
   endtask

   function automatic logic [lla_pkg::COORD_W-1:0] pick_coord(int lim);
      if ($urandom_range(0, 9) == 0) return CRD_W'($urandom_range(0, 127));
      return CRD_W'($urandom_range(0, lim + 1));
   endfunction

   // Random phase: seed the interior, then mix writes, reads, generations and unknown operations.
   task automatic run_random(int count, int max_steps);
      cmd_type cmd;
      int steps, w, h, pick;
      steps = 0;
      w = (cfg_w == 0) ? 1 : (cfg_w > 12 ? 12 : cfg_w);
      h = (cfg_h == 0) ? 1 : (cfg_h > 12 ? 12 : cfg_h);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         cmd.col = pick_coord(w);
         cmd.row = pick_coord(h);
         cmd.cin = $urandom_range(0, 1);
         cmd.has_ref = 1'b0;
         cmd.ref_val = 1'b0;
         if (i < count / 3 || pick < 40) cmd.op = lla_pkg::OP_WRITE;
         else if (pick < 80) cmd.op = lla_pkg::OP_READ;
         else if (pick < 96 && steps < max_steps) begin
            cmd.op = lla_pkg::OP_STEP;
            steps++;
         end else cmd.op = OP_UNKNOWN;
         send_request(cmd);
      end
   endtask

   // Response side: check each beat and stall in random bursts.
   initial begin
      int burst, hold;
      bit nxt_stall;
      bit got;
      rsp_stall = 1'b0;
      burst = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (cell_q.size() == 0) begin
               $error("unexpected response beat, cell_out %0d", rsp_cell_out);
               errors++;
            end else begin
               got = cell_q.pop_front();
               if (rsp_cell_out !== got) begin
                  $error("cell_out expected %0d actual %0d", got, rsp_cell_out);
                  errors++;
               end
            end
         end
         if (long_hold && hold == 0) begin
            long_hold = 1'b0;
            hold = 300;
         end
         // The long hold-off counts only cycles in which a beat waits.
         if (hold > 0) begin
            if (rsp_valid) hold--;
            nxt_stall = 1'b1;
         end else if (quiet) nxt_stall = 1'b0;
         else if (burst > 0) begin
            burst--;
            nxt_stall = 1'b1;
         end else if ($urandom_range(0, 4) == 0) begin
            burst = $urandom_range(0, 6);
            nxt_stall = 1'b1;
         end else nxt_stall = 1'b0;
         rsp_stall <= nxt_stall;
      end
   end

   // Watchdog.
   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

   // Request side and run control.
   initial begin
      errors = 0;
      quiet = 1'b0;
      long_hold = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = lla_pkg::OP_WRITE;
      req_column = '0;
      req_row = '0;
      req_cell_in = 1'b0;
      csr_write_en = 1'b0;
      csr_index = lla_pkg::REG_WIDTH;
      csr_write_data = '0;
      cur_sel = 1'b0;
      cfg_w = lla_pkg::WIDTH_RST; cfg_h = lla_pkg::HEIGHT_RST;
      cfg_wrap = lla_pkg::WRAP_PLANE;
      cfg_survive = lla_pkg::SURVIVE_RST; cfg_birth = lla_pkg::BIRTH_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table under the reset settings.
      for (int i = 0; i < N_DIR; i++) send_request(DIRECTED[i]);
      wait_idle();

      // Torus with a long receiver hold-off that holds off further requests.
      write_regs(5, 4, lla_pkg::WRAP_TORUS, 9'd12, 9'd8);
      long_hold = 1'b1;
      run_random(12, 3);
      wait_idle();
      // Zero size acts as one cell; all-ones masks.
      write_regs(0, 0, lla_pkg::WRAP_PLANE, 9'h1FF, 9'h1FF);
      run_random(8, 3);
      wait_idle();
      write_regs(6, 6, lla_pkg::WRAP_SPHERE, 9'($urandom), 9'($urandom));
      run_random(12, 3);
      wait_idle();
      // Sphere on a non-square grid.
      write_regs(5, 7, lla_pkg::WRAP_SPHERE, 9'd12, 9'd8);
      run_random(10, 3);
      wait_idle();
      write_regs(4, 6, lla_pkg::WRAP_MOBIUS, 9'($urandom), 9'($urandom));
      run_random(10, 3);
      wait_idle();
      write_regs(7, 5, lla_pkg::WRAP_KLEIN, 9'd12, 9'd8);
      run_random(10, 3);
      wait_idle();
      write_regs(6, 4, lla_pkg::WRAP_PROJECTIVE, 9'($urandom), 9'($urandom));
      run_random(10, 3);
      wait_idle();
      write_regs(3, 5, lla_pkg::WRAP_RING, 9'd0, 9'd0);
      run_random(8, 2);
      wait_idle();
      // Unknown topology and oversize width, at most one full-size generation.
      write_regs(127, 64, WRAP_UNKNOWN, 9'd12, 9'd8);
      run_random(8, 1);
      wait_idle();
      // Last part runs without idling on either side.
      write_regs(8, 8, lla_pkg::WRAP_TORUS, 9'd12, 9'd8);
      quiet = 1'b1;
      run_random(14, 3);
      wait_idle();

      repeat (50) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
